FILE: design/cfu_pkg.sv
// Shared types, constants and the field-settling function of the CSV field unescaper.
package cfu_pkg;

    localparam logic [7:0] CFU_DELIM_RST  = 8'd44;  // ','
    localparam logic [7:0] CFU_QUOTE_RST  = 8'd34;  // '"'
    localparam logic [7:0] CFU_ESCAPE_RST = 8'd92;  // '\'

    localparam int CFU_MAX_RES    = 3;
    localparam int CFU_RBUF_DEPTH = 4;

    typedef enum logic [1:0] {
        CFG_DELIMITER = 2'd0,
        CFG_QUOTE     = 2'd1,
        CFG_ESCAPE    = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] delimiter_char;
        logic [7:0] quote_char;
        logic [7:0] escape_char;
    } t_cfg;

    typedef struct packed {
        logic [7:0] held_byte;
        logic       held_valid;
        logic       field_open;
        logic       in_quotes;
        logic       skip_to_delimiter;
        logic       escape_blocked;
    } t_row_state;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] field_byte;
        logic       field_end;
        logic       row_end;
    } t_result;

    typedef struct packed {
        logic [1:0]                count;
        t_result [CFU_MAX_RES-1:0] res;
    } t_step_res;

    typedef struct packed {
        t_row_state s;
        t_result    r;
    } t_settle;

    typedef struct packed {
        logic valid;
        logic space;
    } t_rbuf_stat;

    // Decide a byte: it either closes the field or is emitted as data.
    function automatic t_settle cfu_settle(t_row_state s, t_cfg c, logic [7:0] b,
                                           logic dbl);
        t_settle o;
        logic    stop;
        o   = '0;
        o.s = s;
        if (s.in_quotes && !dbl) begin
            stop = (b == c.quote_char);
        end else begin
            stop = (b == c.delimiter_char);
        end
        if (stop) begin
            o.r.field_end         = 1'b1;
            o.s.skip_to_delimiter = s.in_quotes;
            o.s.field_open        = 1'b0;
            o.s.in_quotes         = 1'b0;
        end else begin
            o.r.has_byte   = 1'b1;
            o.r.field_byte = b;
        end
        return o;
    endfunction

endpackage

FILE: design/cfu_step.sv
// Combinational decode of one row byte into up to three results and the next row state.
module cfu_step
    import cfu_pkg::*;
(
    input  t_cfg       i_cfg,
    input  t_row_state i_state,
    input  logic [7:0] i_row_byte,
    input  logic       i_row_last,
    output t_row_state o_state,
    output t_step_res  o_res
);

    always_comb begin
        t_row_state s;
        t_settle    st;
        logic [1:0] n;
        logic       do_take;
        logic       go;
        logic [7:0] h;

        s       = i_state;
        n       = 2'd0;
        o_res   = '0;
        do_take = 1'b1;
        go      = 1'b0;
        st      = '0;
        h       = s.held_byte;

        // held quote: doubled quote or a lone one
        if (s.held_valid) begin
            s.held_valid = 1'b0;
            s.held_byte  = 8'd0;
            do_take      = (i_row_byte != i_cfg.quote_char);
            st           = cfu_settle(s, i_cfg, h, !do_take);
            s            = st.s;
            o_res.res[n] = st.r;
            n            = n + 2'd1;
        end

        if (do_take) begin
            if (s.skip_to_delimiter) begin
                if (i_row_byte == i_cfg.delimiter_char)
                    s.skip_to_delimiter = 1'b0;
            end else begin
                go = 1'b1;
                if (!s.field_open) begin
                    s.field_open     = 1'b1;
                    s.escape_blocked = 1'b0;
                    s.in_quotes      = (i_row_byte == i_cfg.quote_char);
                    if (s.in_quotes)
                        go = 1'b0;
                end
                if (go && !s.escape_blocked && i_row_byte == i_cfg.escape_char
                        && !i_row_last) begin
                    s.escape_blocked = 1'b1;
                    go               = 1'b0;
                end
                if (go) begin
                    s.escape_blocked = 1'b0;
                    if (i_row_byte == i_cfg.quote_char && !i_row_last) begin
                        s.held_byte  = i_row_byte;
                        s.held_valid = 1'b1;
                    end else begin
                        st           = cfu_settle(s, i_cfg, i_row_byte, 1'b0);
                        s            = st.s;
                        o_res.res[n] = st.r;
                        n            = n + 2'd1;
                    end
                end
            end
        end

        if (i_row_last) begin
            if (s.field_open) begin
                o_res.res[n]           = '0;
                o_res.res[n].field_end = 1'b1;
                n                      = n + 2'd1;
            end
            if (n == 2'd0) begin
                o_res.res[n] = '0;
                n            = n + 2'd1;
            end
            o_res.res[n - 2'd1].row_end = 1'b1;
            s                           = '0;
        end

        o_res.count = n;
        o_state     = s;
    end

endmodule

FILE: design/cfu_rbuf.sv
// Result buffer: takes up to three results a cycle, delivers one a cycle while popped.
module cfu_rbuf
    import cfu_pkg::*;
#(
    parameter int DEPTH = CFU_RBUF_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_step_res  i_push,
    input  logic       i_pop,
    output t_result    o_head,
    output t_rbuf_stat o_stat
);

    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_q [DEPTH];
    t_result         n_q [DEPTH];
    t_result         sh  [DEPTH];
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   n_cnt;
    logic [CW-1:0]   live;
    logic [CW-1:0]   off  [DEPTH];

    always_comb begin
        live = r_cnt - CW'(i_pop);
        for (int i = 0; i < DEPTH - 1; i++)
            sh[i] = i_pop ? r_q[i + 1] : r_q[i];
        sh[DEPTH-1] = r_q[DEPTH-1];
        for (int i = 0; i < DEPTH; i++) begin
            off[i] = CW'(i) - live;
            if (CW'(i) >= live && off[i] < CW'(i_push.count))
                n_q[i] = i_push.res[off[i][1:0]];
            else
                n_q[i] = sh[i];
        end
        n_cnt = live + CW'(i_push.count);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++)
            r_q[i] <= n_q[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_head       = r_q[0];
    assign o_stat.valid = (r_cnt != '0);
    // room for a whole item's results, counted before this cycle's pop
    assign o_stat.space = (r_cnt <= CW'(DEPTH - CFU_MAX_RES));

endmodule

FILE: design/csv_field_unescaper_top.sv
// Top level of the CSV field unescaper: config registers, row state and result buffer.
//
// Takes one row byte per request, with a last-of-row mark, and gives the unescaped bytes
// of each field as results, each field closed by a field-end result and the last result
// of a row carrying row_end. A byte can cause up to three results and the result side
// delivers one per cycle while the output is not stalled. A byte is accepted in any cycle
// in which the result buffer holds at most DEPTH-3 results (one with the default depth of
// four), so with the output taking a result every cycle the block accepts one byte per
// cycle while bytes give at most one result each; bytes that close a held quote or end a
// row can give more, and the input stalls while the buffer drains them. A byte's results
// enter the buffer in the cycle after it is accepted; the first can be taken in that
// cycle if no earlier results wait ahead. Config registers (delimiter, quote, escape)
// are written through a plain write port and should only change while the block is idle.
module csv_field_unescaper_top
    import cfu_pkg::*;
#(
    parameter int RBUF_DEPTH = CFU_RBUF_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // config write port
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    // row bytes in
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_row_byte,
    input  logic       i_row_last,
    // results out
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_has_byte,
    output logic [7:0] o_field_byte,
    output logic       o_field_end,
    output logic       o_row_end
);

    t_cfg       r_cfg;
    t_row_state r_state;
    t_row_state n_state;
    t_step_res  step_res;
    t_step_res  push;
    t_result    head;
    t_rbuf_stat stat;
    logic       in_acc;
    logic       out_acc;

    // config registers; writes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delimiter_char <= CFU_DELIM_RST;
            r_cfg.quote_char     <= CFU_QUOTE_RST;
            r_cfg.escape_char    <= CFU_ESCAPE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DELIMITER: r_cfg.delimiter_char <= i_cfg_data;
                CFG_QUOTE:     r_cfg.quote_char     <= i_cfg_data;
                CFG_ESCAPE:    r_cfg.escape_char    <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    assign o_stall = !stat.space;
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    cfu_step u_step (
        .i_cfg      (r_cfg),
        .i_state    (r_state),
        .i_row_byte (i_row_byte),
        .i_row_last (i_row_last),
        .o_state    (n_state),
        .o_res      (step_res)
    );

    // row state moves only on an accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        push = step_res;
        if (!in_acc)
            push.count = 2'd0;
    end

    cfu_rbuf #(
        .DEPTH (RBUF_DEPTH)
    ) u_rbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (out_acc),
        .o_head  (head),
        .o_stat  (stat)
    );

    assign o_valid      = stat.valid;
    assign o_has_byte   = head.has_byte;
    assign o_field_byte = head.field_byte;
    assign o_field_end  = head.field_end;
    assign o_row_end    = head.row_end;

    // a row end always leaves a clean row state behind
    a_row_clear : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_row_last |=> r_state == '0)
        else $error("row state not cleared after row end");

    // every row end produces at least one result
    a_row_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_row_last |-> step_res.count != 2'd0)
        else $error("row end without result");

    // after a closing quote no field is open
    a_skip_closed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.skip_to_delimiter |-> !r_state.field_open && !r_state.held_valid)
        else $error("skipping while a field is open");

    // a held quote only exists inside an open field
    a_held_open : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.held_valid |-> r_state.field_open)
        else $error("held quote outside an open field");

    // stalling the input only ever happens with results waiting
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty result buffer");

endmodule
